[rtl/ffha_pkg.sv]
// shared constants, codes and controller/datapath signal groups for the heap allocator
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int SPLIT_SLACK      = 16;
  localparam logic [31:0] HEAP_BASE_RESET = 32'h0100_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_ADR = 2'd2;

  localparam logic REG_HEAP_BASE = 1'b0;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_IDX,
    RD_NX
  } rd_src_t;

  typedef struct packed {
    logic       init;
    logic       start;
    logic       rd_en;
    rd_src_t    rd_src;
    logic       keep;
    logic       adv_cur;
    logic       idx_clr;
    logic       idx_inc;
    logic       wr_split;
    logic       wr_cur;
    logic       take;
    logic       mark_free;
    logic       merge;
    logic       set_res;
    logic [1:0] res_code;
    logic       out_load;
    logic       in_ready;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic op_free;
    logic addr_zero;
    logic fit;
    logic split_due;
    logic spare_free;
    logic idx_last;
    logic next_nil;
    logic match;
    logic nx_free;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/ffha_if.sv]
// request and response channel interfaces
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [19:0] request_size;
  logic [31:0] free_address;
  modport source (output valid, opcode, request_size, free_address, input ready);
  modport sink (input valid, opcode, request_size, free_address, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] payload_address;
  modport source (output valid, status, payload_address, input ready);
  modport sink (input valid, status, payload_address, output ready);
endinterface

[rtl/ffha_ctrl.sv]
// controller state machine sequencing list walk, record scans and updates
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  ffha_pkg::dp_status_t sts,
  output ffha_pkg::ctrl_cmd_t  cmd
);
  import ffha_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_EV   = 4'd3;
  localparam logic [3:0] S_A_SP   = 4'd4;
  localparam logic [3:0] S_A_W1   = 4'd5;
  localparam logic [3:0] S_A_W2   = 4'd6;
  localparam logic [3:0] S_A_TAKE = 4'd7;
  localparam logic [3:0] S_F_RD   = 4'd8;
  localparam logic [3:0] S_F_EV   = 4'd9;
  localparam logic [3:0] S_F_RDN  = 4'd10;
  localparam logic [3:0] S_F_MG   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_src = RD_CUR;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.start = 1'b1;
          if (!sts.op_free) begin
            state_next = S_A_RD;
          end else if (sts.addr_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_DONE;
          end else begin
            state_next = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_CUR;
        state_next = S_A_EV;
      end
      S_A_EV: begin
        if (sts.fit) begin
          if (sts.split_due) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_A_SP;
          end else begin
            state_next = S_A_TAKE;
          end
        end else if (sts.idx_last || sts.next_nil) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_FIT;
          state_next   = S_DONE;
        end else begin
          cmd.adv_cur = 1'b1;
          state_next  = S_A_RD;
        end
      end
      S_A_SP: begin
        if (sts.spare_free) begin
          state_next = S_A_W1;
        end else if (sts.idx_last) begin
          state_next = S_A_TAKE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_A_W1: begin
        cmd.wr_split = 1'b1;
        state_next   = S_A_W2;
      end
      S_A_W2: begin
        cmd.wr_cur = 1'b1;
        state_next = S_A_TAKE;
      end
      S_A_TAKE: begin
        cmd.take   = 1'b1;
        state_next = S_DONE;
      end
      S_F_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_IDX;
        state_next = S_F_EV;
      end
      S_F_EV: begin
        if (sts.match) begin
          cmd.mark_free = 1'b1;
          cmd.keep      = 1'b1;
          if (sts.nx_free) begin
            state_next = S_F_RDN;
          end else begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_OK;
            state_next   = S_DONE;
          end
        end else if (sts.idx_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_BAD_ADR;
          state_next   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_F_RD;
        end
      end
      S_F_RDN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_NX;
        state_next = S_F_MG;
      end
      S_F_MG: begin
        cmd.merge    = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

[rtl/ffha_dp.sv]
// datapath: block record memory, in-use and free flags, walk registers, result register
module ffha_dp #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         heap_base,
  input  ffha_pkg::ctrl_cmd_t  cmd,
  output ffha_pkg::dp_status_t sts,
  ffha_req_if.sink            req,
  ffha_rsp_if.source          rsp
);
  import ffha_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = $clog2(HEAP_BYTES + 1);
  localparam int RW = SW + SW + NW;
  localparam logic [NW-1:0] NIL = NW'(MAX_BLOCKS);
  localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);

  logic [RW-1:0] mem [MAX_BLOCKS];
  logic [RW-1:0] rd_data;
  logic [RW-1:0] wr_data;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  logic [MAX_BLOCKS-1:0] in_use, blk_free;
  logic [IW-1:0] cur, idx;
  logic [19:0]   req_size;
  logic [31:0]   off;
  logic [SW-1:0] rec_size, rec_off;
  logic [NW-1:0] rec_next;
  logic [1:0]    res_status;
  logic [31:0]   res_addr;
  logic          out_valid;
  logic [1:0]    out_status;
  logic [31:0]   out_addr;

  logic [SW-1:0] rd_off, rd_size;
  logic [NW-1:0] rd_next;
  logic [31:0]   size32, req32;

  assign rd_off  = rd_data[RW-1 -: SW];
  assign rd_size = rd_data[NW +: SW];
  assign rd_next = rd_data[NW-1:0];
  assign size32  = 32'(rd_size);
  assign req32   = 32'(req_size);

  always_comb begin
    unique case (cmd.rd_src)
      RD_CUR:  rd_addr = cur;
      RD_IDX:  rd_addr = idx;
      RD_NX:   rd_addr = rec_next[IW-1:0];
      default: rd_addr = cur;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = rd_data;
    if (cmd.init) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {SW'(0), SW'(HEAP_BYTES - HEADER_BYTES), NIL};
    end else if (cmd.wr_split) begin
      wr_en   = 1'b1;
      wr_addr = idx;
      wr_data = {SW'(32'(rd_off) + 32'(HEADER_BYTES) + req32),
                 SW'(size32 - req32 - 32'(HEADER_BYTES)), rd_next};
    end else if (cmd.wr_cur) begin
      wr_en   = 1'b1;
      wr_addr = cur;
      wr_data = {rd_off, SW'(req32), NW'(idx)};
    end else if (cmd.merge) begin
      wr_en   = 1'b1;
      wr_addr = cur;
      wr_data = {rec_off, SW'(32'(rec_size) + size32 + 32'(HEADER_BYTES)), rd_next};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use   <= MAX_BLOCKS'(1);
      blk_free <= MAX_BLOCKS'(1);
    end else begin
      if (cmd.wr_split) begin
        in_use[idx]   <= 1'b1;
        blk_free[idx] <= 1'b1;
      end
      if (cmd.take) begin
        blk_free[cur] <= 1'b0;
      end
      if (cmd.mark_free) begin
        blk_free[idx] <= 1'b1;
      end
      if (cmd.merge) begin
        in_use[rec_next[IW-1:0]]   <= 1'b0;
        blk_free[rec_next[IW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_size <= req.request_size;
      off      <= req.free_address - heap_base - 32'(HEADER_BYTES);
      res_addr <= '0;
    end
    if (cmd.keep) begin
      rec_off  <= rd_off;
      rec_size <= rd_size;
      rec_next <= rd_next;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
    end
    if (cmd.take) begin
      res_status <= ST_OK;
      res_addr   <= heap_base + 32'(rd_off) + 32'(HEADER_BYTES);
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      idx <= '0;
    end else if (cmd.start || cmd.idx_clr) begin
      cur <= cmd.start ? '0 : cur;
      idx <= '0;
    end else if (cmd.adv_cur) begin
      cur <= rd_next[IW-1:0];
      idx <= idx + 1'b1;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.mark_free) begin
      cur <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign req.ready           = cmd.in_ready;
  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.payload_address = out_addr;

  assign sts.in_valid   = req.valid;
  assign sts.op_free    = (req.opcode == OP_FREE);
  assign sts.addr_zero  = (req.free_address == 32'd0);
  assign sts.fit        = in_use[cur] && blk_free[cur] && (size32 >= req32);
  assign sts.split_due  = size32 > (req32 + 32'(HEADER_BYTES) + 32'(SPLIT_SLACK));
  assign sts.spare_free = !in_use[idx];
  assign sts.idx_last   = (idx == LAST);
  assign sts.next_nil   = (rd_next == NIL);
  assign sts.match      = in_use[idx] && (32'(rd_off) == off);
  assign sts.nx_free    = (rd_next != NIL) && blk_free[rd_next[IW-1:0]];
  assign sts.out_free   = !out_valid || rsp.ready;

endmodule

[rtl/first_fit_heap_allocator.sv]
// top level: first-fit heap allocator with register port
// requests arrive on req (opcode 0 allocate request_size bytes, 1 free
// free_address); each request gives exactly one response on rsp with a
// status and, for a successful allocate, the payload address.
// a transfer happens on a channel when valid and ready are both high.
// allocate walks the address-ordered block list one record at a time through
// the record memory read port; when the chosen block is split it also scans
// for a spare record and writes the split-off record and the shortened one.
// free scans the records for the block header, one record at a time, and
// merges the block with the next one in the list when that block is free.
// one request is in flight at a time; req.ready is high only when idle.
// the response sits in an output register until taken; while it waits the
// next request's work can finish but its response waits in turn.
// reset (synchronous, active high) leaves one free block over the whole
// region; the init state that follows reset writes that record, with req.ready low.
// heap_base is written over the register port at byte address 0; the user
// must write it only while the block is idle, which the block does not enforce.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ffha_req_if.sink    req,
  ffha_rsp_if.source  rsp
);
  import ffha_pkg::*;

  logic [31:0] heap_base;
  ctrl_cmd_t   cmd;
  dp_status_t  sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HEAP_BASE)) begin
      heap_base <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEAP_BASE) ? heap_base : 32'd0;

  ffha_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .heap_base (heap_base),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .rsp       (rsp)
  );

endmodule

[test/testbench.sv]
// testbench for the first-fit heap allocator: own allocator predictor, random traffic, apb setup
`timescale 1ns / 1ps

module testbench;
  import ffha_pkg::*;

  localparam int NREC     = MAX_BLOCKS_DEF;
  localparam int HDR      = HEADER_BYTES_DEF;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    bit        op;
    bit [19:0] size;
    bit [31:0] addr;
  } heap_req_t;

  typedef struct {
    bit        op;
    bit [1:0]  status;
    bit [31:0] payload;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req.sink), .rsp(rsp.source)
  );

  always #10 clk = ~clk;

  heap_req_t   pending_reqs[$];
  heap_rsp_t   expected_rsps[$];
  bit [31:0]   live_offsets[$];
  int          errors = 0;

  // allocator image
  bit [31:0]   heap_base_q;
  bit [31:0]   rec_off[NREC];
  bit [31:0]   rec_size[NREC];
  bit          rec_free[NREC];
  bit          rec_used[NREC];
  int          rec_next[NREC];

  function automatic void image_reset();
    for (int i = 0; i < NREC; i++) begin
      rec_off[i] = 0; rec_size[i] = 0; rec_free[i] = 0; rec_used[i] = 0; rec_next[i] = NREC;
    end
    rec_size[0] = HEAP_BYTES_DEF - HDR;
    rec_free[0] = 1;
    rec_used[0] = 1;
    heap_base_q = HEAP_BASE_RESET;
  endfunction

  function automatic heap_rsp_t heap_apply(heap_req_t r);
    heap_rsp_t res;
    int cur, spare, nx, blk;
    bit [31:0] want, off;
    res.op = r.op;
    res.status = ST_OK;
    res.payload = 0;
    if (r.op == OP_ALLOC) begin
      want = 32'(r.size);
      cur = 0;
      for (int s = 0; s < NREC && cur < NREC; s++) begin
        if (rec_used[cur] && rec_free[cur] && rec_size[cur] >= want) begin
          if (rec_size[cur] > want + HDR + SPLIT_SLACK) begin
            spare = NREC;
            for (int i = NREC - 1; i >= 0; i--) if (!rec_used[i]) spare = i;
            if (spare < NREC) begin
              rec_used[spare] = 1;
              rec_off[spare]  = rec_off[cur] + HDR + want;
              rec_size[spare] = rec_size[cur] - want - HDR;
              rec_free[spare] = 1;
              rec_next[spare] = rec_next[cur];
              rec_next[cur]   = spare;
              rec_size[cur]   = want;
            end
          end
          rec_free[cur] = 0;
          res.payload = heap_base_q + rec_off[cur] + HDR;
          return res;
        end
        cur = rec_next[cur];
      end
      res.status = ST_NO_FIT;
      return res;
    end
    if (r.addr == 0) return res;
    off = r.addr - heap_base_q - HDR;
    blk = NREC;
    for (int i = NREC - 1; i >= 0; i--) if (rec_used[i] && rec_off[i] == off) blk = i;
    if (blk == NREC) begin
      res.status = ST_BAD_ADR;
      return res;
    end
    rec_free[blk] = 1;
    nx = rec_next[blk];
    if (nx < NREC && rec_free[nx]) begin
      rec_size[blk] += rec_size[nx] + HDR;
      rec_next[blk] = rec_next[nx];
      rec_used[nx] = 0; rec_free[nx] = 0; rec_next[nx] = NREC;
      rec_off[nx] = 0; rec_size[nx] = 0;
    end
    return res;
  endfunction

  // request driver
  int unsigned accepted_cnt = 0, seen_cnt = 0;
  int burst_left = 4, gap_left = 0;

  initial begin
    req.valid = 1'b0; req.opcode = 1'b0; req.request_size = '0; req.free_address = '0;
    rsp.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!(req.valid && accepted_cnt == seen_cnt)) begin
      seen_cnt = accepted_cnt;
      if (gap_left > 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req.valid <= 1'b1;
        req.opcode <= pending_reqs[0].op;
        req.request_size <= pending_reqs[0].size;
        req.free_address <= pending_reqs[0].addr;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      expected_rsps.push_back(heap_apply(pending_reqs.pop_front()));
      accepted_cnt++;
    end
  end

  // response sink with its own stall pattern
  int unsigned stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    case ((stall_phase / 64) % 4)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 2) != 0);
      2: rsp.ready <= (stall_phase % 7) < 2;
      default: rsp.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    heap_rsp_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected transfer status %0d payload %h", $time,
                 rsp.status, rsp.payload_address);
        errors++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, rsp.status);
          errors++;
        end
        if (rsp.payload_address !== exp_r.payload) begin
          $display("%0t: payload_address expected %h actual %h", $time, exp_r.payload,
                   rsp.payload_address);
          errors++;
        end
        if (exp_r.op == OP_ALLOC && exp_r.status == ST_OK)
          live_offsets.push_back(exp_r.payload - heap_base_q - HDR);
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (pending_reqs.size() == 0 && expected_rsps.size() == 0))
      idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_heap_base(input bit [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(REG_HEAP_BASE) * 3'd4; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    heap_base_q = value;
    live_offsets.delete();
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic void push_alloc(input bit [19:0] size);
    heap_req_t r;
    r.op = OP_ALLOC; r.size = size; r.addr = $urandom;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_free(input bit [31:0] addr);
    heap_req_t r;
    r.op = OP_FREE; r.size = 20'($urandom); r.addr = addr;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_random(input int alloc_pct);
    int pick, k;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      case ($urandom_range(0, 19))
        0: push_alloc(20'($urandom));
        1, 2: push_alloc(20'($urandom_range(0, 65535)));
        default: push_alloc(20'($urandom_range(0, 300)));
      endcase
    end else if (pick < 92 && live_offsets.size() > 0) begin
      k = $urandom_range(0, live_offsets.size() - 1);
      push_free(heap_base_q + live_offsets[k] + HDR);
      if ($urandom_range(0, 7) != 0) live_offsets.delete(k);
    end else if (pick < 96) begin
      push_free(32'd0);
    end else begin
      push_free($urandom);
    end
  endfunction

  bit [31:0] base_list[5];
  int alloc_pct_list[5];

  initial begin
    image_reset();
    base_list = '{HEAP_BASE_RESET, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_0000};
    base_list[3] = $urandom;
    alloc_pct_list = '{55, 85, 50, 70, 45};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_heap_base(HEAP_BASE_RESET);
    push_alloc(20'd0);
    push_free(HEAP_BASE_RESET + HDR);
    push_alloc(20'(HEAP_BYTES_DEF - HDR));
    push_alloc(20'd1);
    push_free(HEAP_BASE_RESET + HDR);
    push_alloc(20'(HEAP_BYTES_DEF - HDR + 1));
    push_alloc(20'hFFFFF);
    push_free(32'd0);
    push_free(32'hFFFF_FFFF);
    push_free(HEAP_BASE_RESET + 8);
    push_alloc(20'd100);
    push_alloc(20'd32);
    push_alloc(20'd33);
    push_free(HEAP_BASE_RESET + HDR);
    push_free(HEAP_BASE_RESET + HDR);
    push_free(HEAP_BASE_RESET + HDR + 100 + HDR);
    push_alloc(20'd50);
    push_free(HEAP_BASE_RESET + HDR);
    for (int i = 0; i < 6; i++) push_alloc(20'd16);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_heap_base(base_list[ph]);
      for (int n = 0; n < 130; n += 10) begin
        for (int j = 0; j < 10; j++) push_random(alloc_pct_list[ph]);
        wait_drained();
      end
    end

    repeat (400) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
